// ----- rtl/core/ntc_pkg.sv -----
// ----------------------------------------------------------------------------
// NTC converter package
// Shared widths, codes, constant tables and control structs of the converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int ADC_BITS = 16;
  localparam int CHANNELS = 8;

  localparam int CODE_W   = 16;
  localparam int CH_W     = 3;
  localparam int OHM_W    = 17;
  localparam int BETA_W   = 16;
  localparam int MV_W     = 13;
  localparam int TEMP_W   = 16;
  localparam int STAT_W   = 2;

  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam int PV_W     = MV_W + ADC_BITS;
  localparam int QV_W     = CODE_W + MV_W;
  localparam int VW       = (PV_W > QV_W) ? PV_W : QV_W;
  localparam int N_W      = VW + OHM_W;
  localparam int D_W      = QV_W + OHM_W;
  localparam int DV_W     = D_W;
  localparam int CW1      = (N_W > D_W + 16) ? N_W : D_W + 16;
  localparam int LN_W     = 23;
  localparam int PROD_W   = 32;
  localparam int DEN_W    = 42;
  localparam int NUMB_W   = 38;
  localparam int X_W      = NUMB_W + 17;
  localparam int CW2      = DEN_W + 17;
  localparam int CNT_W    = 6;

  localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
  localparam logic [16:0]         LN2_Q16    = 17'd45426;
  localparam logic [22:0]         K_BETA_DEN = 23'd6553600;
  localparam logic [14:0]         K_LN_DEN   = 15'd29815;
  localparam logic [21:0]         K_NUM      = 22'd2981500;
  localparam logic [16:0]         Q_MAX      = 17'd60082;
  localparam logic [16:0]         K_OFFSET   = 17'd27315;
  localparam logic [TEMP_W-1:0]   TEMP_SAT   = 16'h7FFF;

  localparam logic [BETA_W-1:0] BETA_RESET    = 16'd3977;
  localparam logic [OHM_W-1:0]  NOMINAL_RESET = 17'd10000;
  localparam logic [MV_W-1:0]   SUPPLY_RESET  = 13'd3300;
  localparam logic [MV_W-1:0]   ADCREF_RESET  = 13'd2500;

  typedef enum logic [1:0] {
    REG_BETA    = 2'd0,
    REG_NOMINAL = 2'd1,
    REG_SUPPLY  = 2'd2,
    REG_ADCREF  = 2'd3
  } reg_idx_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CONV = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_NPOS = 2'd2;
  localparam logic [STAT_W-1:0] ST_LOAD = 2'd3;

  typedef struct packed {
    logic accept;
    logic mul1;
    logic mul2;
    logic chk1;
    logic take_ratio;
    logic norm;
    logic ln1;
    logic ln2;
    logic den1;
    logic den2;
    logic den3;
    logic chk2;
    logic take_temp;
    logic load_out;
  } ntc_cmd_t;

  typedef struct packed {
    logic zero_code;
    logic not_pos;
    logic ratio_sat;
    logic ratio_zero;
    logic norm_done;
    logic den_nonpos;
    logic temp_sat;
    logic div_busy;
  } ntc_stat_t;

  function automatic logic [15:0] ln_tab(input logic [5:0] i);
    logic [15:0] v;
    unique case (i)
      6'd0:  v = 16'd0;
      6'd1:  v = 16'd2017;
      6'd2:  v = 16'd3973;
      6'd3:  v = 16'd5873;
      6'd4:  v = 16'd7719;
      6'd5:  v = 16'd9515;
      6'd6:  v = 16'd11262;
      6'd7:  v = 16'd12965;
      6'd8:  v = 16'd14624;
      6'd9:  v = 16'd16242;
      6'd10: v = 16'd17821;
      6'd11: v = 16'd19364;
      6'd12: v = 16'd20870;
      6'd13: v = 16'd22343;
      6'd14: v = 16'd23783;
      6'd15: v = 16'd25193;
      6'd16: v = 16'd26573;
      6'd17: v = 16'd27924;
      6'd18: v = 16'd29248;
      6'd19: v = 16'd30546;
      6'd20: v = 16'd31818;
      6'd21: v = 16'd33067;
      6'd22: v = 16'd34292;
      6'd23: v = 16'd35494;
      6'd24: v = 16'd36675;
      6'd25: v = 16'd37835;
      6'd26: v = 16'd38975;
      6'd27: v = 16'd40095;
      6'd28: v = 16'd41196;
      6'd29: v = 16'd42280;
      6'd30: v = 16'd43345;
      6'd31: v = 16'd44394;
      6'd32: v = 16'd45426;
      default: v = 16'd45426;
    endcase
    return v;
  endfunction

  function automatic logic [OHM_W-1:0] series_init(input int k);
    logic [OHM_W-1:0] v;
    unique case (k)
      0: v = 17'd10040;
      1: v = 17'd10020;
      3: v = 17'd10020;
      5: v = 17'd10010;
      default: v = 17'd10000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/ntc_div.sv -----
// ----------------------------------------------------------------------------
// NTC restoring divider
// Shared unsigned divider, one quotient bit per cycle, for ratio and temperature.
// ----------------------------------------------------------------------------
module ntc_div
  import ntc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DV_W-1:0]  rem_init,
  input  logic [31:0]      bits_init,
  input  logic [CNT_W-1:0] iters,
  input  logic [DV_W-1:0]  divisor,
  output logic             busy,
  output logic [31:0]      quot
);

  logic [DV_W-1:0]  rem;
  logic [31:0]      bits;
  logic [DV_W-1:0]  dvs;
  logic [CNT_W-1:0] cnt;
  logic [DV_W:0]    trial;

  assign trial = {rem, bits[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
      rem  <= rem_init;
      bits <= bits_init;
      dvs  <= divisor;
      quot <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem  <= DV_W'(trial - {1'b0, dvs});
        quot <= {quot[30:0], 1'b1};
      end else begin
        rem  <= trial[DV_W-1:0];
        quot <= {quot[30:0], 1'b0};
      end
      bits <= {bits[30:0], 1'b0};
      cnt  <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/ntc_dp.sv -----
// ----------------------------------------------------------------------------
// NTC datapath
// Series table, products, log interpolation, divider use and result register.
// ----------------------------------------------------------------------------
module ntc_dp
  import ntc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ntc_cmd_t          cmd,
  output ntc_stat_t         st,
  input  logic              command,
  input  logic [CH_W-1:0]   channel,
  input  logic [CODE_W-1:0] adc_code,
  input  logic [OHM_W-1:0]  series_ohm,
  input  logic [BETA_W-1:0] beta_kelvin,
  input  logic [OHM_W-1:0]  nominal_ohm,
  input  logic [MV_W-1:0]   supply_mv,
  input  logic [MV_W-1:0]   adc_ref_mv,
  output logic [TEMP_W-1:0] temp_centi_c,
  output logic [STAT_W-1:0] status,
  output logic [CH_W-1:0]   channel_out
);

  logic [OHM_W-1:0]  series_table [CHANNELS];
  logic [CH_W-1:0]   ch_r;
  logic [CODE_W-1:0] code_r;
  logic [PV_W-1:0]   pv;
  logic [QV_W-1:0]   qv;
  logic [OHM_W-1:0]  rs;
  logic [OHM_W-1:0]  rs_sel;
  logic [N_W-1:0]    n;
  logic [D_W-1:0]    d;
  logic [31:0]       m;
  logic [4:0]        p;
  logic [PROD_W-1:0] prod;
  logic signed [LN_W-1:0] base;
  logic signed [LN_W-1:0] base_next;
  logic signed [LN_W-1:0] lnq;
  logic [DEN_W-2:0]  a_r;
  logic signed [DEN_W-1:0] b_r;
  logic signed [DEN_W-1:0] den;
  logic [NUMB_W-1:0] numb;
  logic [X_W-1:0]    x;
  logic [TEMP_W-1:0] res_temp;
  logic [STAT_W-1:0] res_status;
  logic [VW-1:0]     diff_v;
  logic [15:0]       ln_lo;
  logic [15:0]       ln_step;
  logic [16:0]       q17;

  logic              div_start;
  logic [DV_W-1:0]   div_rem;
  logic [31:0]       div_bits;
  logic [CNT_W-1:0]  div_iters;
  logic [DV_W-1:0]   div_dvs;
  logic              div_busy;
  logic [31:0]       div_q;

  always_comb begin
    rs_sel = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (int'(ch_r) == k) begin
        rs_sel = series_table[k];
      end
    end
  end

  assign diff_v  = VW'(pv) - VW'(qv);
  assign ln_lo   = ln_tab({1'b0, m[30:26]});
  assign ln_step = ln_tab(6'({1'b0, m[30:26]}) + 6'd1) - ln_lo;
  assign q17     = div_q[16:0];

  always_comb begin
    logic signed [LN_W-1:0] pm;
    pm        = LN_W'(signed'({1'b0, p})) - LN_W'(16);
    base_next = pm * signed'(LN_W'(LN2_Q16)) + signed'(LN_W'(ln_lo));
  end

  assign st.zero_code  = (qv == '0);
  assign st.not_pos    = (VW'(pv) <= VW'(qv)) || (nominal_ohm == '0);
  assign st.ratio_sat  = (CW1'(n) >= CW1'({d, 16'b0}));
  assign st.ratio_zero = (div_q == '0);
  assign st.norm_done  = m[31];
  assign st.den_nonpos = den[DEN_W-1] || (den == '0);
  assign st.temp_sat   = (CW2'(x) >= CW2'({den, 17'b0}));
  assign st.div_busy   = div_busy;

  always_comb begin
    div_start = 1'b0;
    div_rem   = DV_W'(n >> 16);
    div_bits  = {n[15:0], 16'b0};
    div_iters = CNT_W'(32);
    div_dvs   = d;
    if (cmd.chk1) begin
      div_start = !st.ratio_sat;
    end else if (cmd.chk2) begin
      div_start = !st.temp_sat;
      div_rem   = DV_W'(x >> 17);
      div_bits  = {x[16:0], 15'b0};
      div_iters = CNT_W'(17);
      div_dvs   = DV_W'(den[DEN_W-2:0]);
    end
  end

  ntc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .rem_init  (div_rem),
    .bits_init (div_bits),
    .iters     (div_iters),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .quot      (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        series_table[k] <= series_init(k);
      end
    end else if (cmd.accept && command == CMD_LOAD) begin
      for (int k = 0; k < CHANNELS; k++) begin
        if (int'(channel) == k) begin
          series_table[k] <= series_ohm;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r       <= channel;
      code_r     <= adc_code;
      res_temp   <= '0;
      res_status <= (command == CMD_LOAD) ? ST_LOAD : ST_OK;
    end
    if (cmd.mul1) begin
      pv <= PV_W'(supply_mv) * PV_W'(FULL_SCALE);
      qv <= QV_W'(code_r) * QV_W'(adc_ref_mv);
      rs <= rs_sel;
    end
    if (cmd.mul2) begin
      n <= N_W'(diff_v) * N_W'(nominal_ohm);
      d <= D_W'(qv) * D_W'(rs);
      if (st.zero_code) begin
        res_status <= ST_ZERO;
      end else if (st.not_pos) begin
        res_status <= ST_NPOS;
      end
    end
    if (cmd.chk1) begin
      m <= '1;
      p <= 5'd31;
    end
    if (cmd.take_ratio) begin
      m <= div_q;
      p <= 5'd31;
      if (st.ratio_zero) begin
        res_status <= ST_NPOS;
      end
    end
    if (cmd.norm && !m[31]) begin
      m <= {m[30:0], 1'b0};
      p <= p - 5'd1;
    end
    if (cmd.ln1) begin
      prod <= PROD_W'(ln_step) * PROD_W'(m[25:10]);
      base <= base_next;
    end
    if (cmd.ln2) begin
      lnq <= base + signed'(LN_W'((prod + PROD_W'(32768)) >> 16));
    end
    if (cmd.den1) begin
      a_r <= (DEN_W-1)'(beta_kelvin) * (DEN_W-1)'(K_BETA_DEN);
      b_r <= DEN_W'(lnq) * signed'(DEN_W'(K_LN_DEN));
    end
    if (cmd.den2) begin
      den  <= signed'({1'b0, a_r}) - b_r;
      numb <= NUMB_W'(beta_kelvin) * NUMB_W'(K_NUM);
    end
    if (cmd.den3) begin
      if (st.den_nonpos) begin
        res_temp <= TEMP_SAT;
      end else begin
        x <= X_W'({numb, 16'b0}) + X_W'(den[DEN_W-2:1]);
      end
    end
    if (cmd.chk2 && st.temp_sat) begin
      res_temp <= TEMP_SAT;
    end
    if (cmd.take_temp) begin
      if (q17 > Q_MAX) begin
        res_temp <= TEMP_SAT;
      end else begin
        res_temp <= TEMP_W'(q17 - K_OFFSET);
      end
    end
    if (cmd.load_out) begin
      temp_centi_c <= res_temp;
      status       <= res_status;
      channel_out  <= ch_r;
    end
  end

endmodule

// ----- rtl/core/ntc_ctrl.sv -----
// ----------------------------------------------------------------------------
// NTC controller
// Sequences one conversion or load through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module ntc_ctrl
  import ntc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      command,
  output logic      out_valid,
  input  logic      out_ready,
  input  ntc_stat_t st,
  output ntc_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_MUL1 = 14'b00000000000010,
    S_MUL2 = 14'b00000000000100,
    S_CHK1 = 14'b00000000001000,
    S_DIV1 = 14'b00000000010000,
    S_NORM = 14'b00000000100000,
    S_LN1  = 14'b00000001000000,
    S_LN2  = 14'b00000010000000,
    S_DEN1 = 14'b00000100000000,
    S_DEN2 = 14'b00001000000000,
    S_DEN3 = 14'b00010000000000,
    S_CHK2 = 14'b00100000000000,
    S_DIV2 = 14'b01000000000000,
    S_FIN  = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = (command == CMD_CONV) ? S_MUL1 : S_FIN;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = (st.zero_code || st.not_pos) ? S_FIN : S_CHK1;
      end
      S_CHK1: begin
        cmd.chk1   = 1'b1;
        state_next = st.ratio_sat ? S_NORM : S_DIV1;
      end
      S_DIV1: begin
        if (!st.div_busy) begin
          cmd.take_ratio = 1'b1;
          state_next     = st.ratio_zero ? S_FIN : S_NORM;
        end
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        if (st.norm_done) begin
          state_next = S_LN1;
        end
      end
      S_LN1: begin
        cmd.ln1    = 1'b1;
        state_next = S_LN2;
      end
      S_LN2: begin
        cmd.ln2    = 1'b1;
        state_next = S_DEN1;
      end
      S_DEN1: begin
        cmd.den1   = 1'b1;
        state_next = S_DEN2;
      end
      S_DEN2: begin
        cmd.den2   = 1'b1;
        state_next = S_DEN3;
      end
      S_DEN3: begin
        cmd.den3   = 1'b1;
        state_next = st.den_nonpos ? S_FIN : S_CHK2;
      end
      S_CHK2: begin
        cmd.chk2   = 1'b1;
        state_next = st.temp_sat ? S_FIN : S_DIV2;
      end
      S_DIV2: begin
        if (!st.div_busy) begin
          cmd.take_temp = 1'b1;
          state_next    = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/ntc_beta_temperature_converter.sv -----
// ----------------------------------------------------------------------------
// NTC Beta temperature converter
// Turns thermistor divider ADC codes into centi-degrees Celsius by the Beta
// equation, with per-channel series resistance and an APB register port.
//
//   channel  direction  beat
//   in       input      command, channel, adc_code, series_ohm
//   out      output     temp_centi_c, status, channel_out
//   apb      config     beta_kelvin, nominal_ohm, supply_mv, adc_ref_mv
//
// A load result goes from acceptance straight to the final state, a zero code
// or non-positive difference after the two product states and a zero ratio
// after the ratio division. A full conversion runs the ratio division in the
// shared divider, single-bit normalization and then the temperature division.
// One item is in work at a time; the next is accepted once the result sits in
// the output register, while that result may still be waiting for out_ready.
// Reset is synchronous and restores the registers and the series table.
// ----------------------------------------------------------------------------
module ntc_beta_temperature_converter
  import ntc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [CH_W-1:0]   channel,
  input  logic [CODE_W-1:0] adc_code,
  input  logic [OHM_W-1:0]  series_ohm,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TEMP_W-1:0] temp_centi_c,
  output logic [STAT_W-1:0] status,
  output logic [CH_W-1:0]   channel_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [BETA_W-1:0] beta_kelvin;
  logic [OHM_W-1:0]  nominal_ohm;
  logic [MV_W-1:0]   supply_mv;
  logic [MV_W-1:0]   adc_ref_mv;
  logic              wr_en;
  reg_idx_t          reg_idx;
  ntc_cmd_t          cmd;
  ntc_stat_t         st;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_kelvin <= BETA_RESET;
      nominal_ohm <= NOMINAL_RESET;
      supply_mv   <= SUPPLY_RESET;
      adc_ref_mv  <= ADCREF_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BETA:    beta_kelvin <= pwdata[BETA_W-1:0];
        REG_NOMINAL: nominal_ohm <= pwdata[OHM_W-1:0];
        REG_SUPPLY:  supply_mv   <= pwdata[MV_W-1:0];
        REG_ADCREF:  adc_ref_mv  <= pwdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BETA:    prdata = DATA_W'(beta_kelvin);
      REG_NOMINAL: prdata = DATA_W'(nominal_ohm);
      REG_SUPPLY:  prdata = DATA_W'(supply_mv);
      REG_ADCREF:  prdata = DATA_W'(adc_ref_mv);
      default:     prdata = '0;
    endcase
  end

  ntc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ntc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .command      (command),
    .channel      (channel),
    .adc_code     (adc_code),
    .series_ohm   (series_ohm),
    .beta_kelvin  (beta_kelvin),
    .nominal_ohm  (nominal_ohm),
    .supply_mv    (supply_mv),
    .adc_ref_mv   (adc_ref_mv),
    .temp_centi_c (temp_centi_c),
    .status       (status),
    .channel_out  (channel_out)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC converter testbench
// Drives load and convert beats with random bursts and gaps, stalls the
// result side on a changing pattern, and checks every result against an
// in-bench fixed-point model of the Beta equation under several register sets.
// ----------------------------------------------------------------------------
module tb_top;
  import ntc_pkg::*;

  typedef struct {
    logic              cmd;
    logic [CH_W-1:0]   ch;
    logic [CODE_W-1:0] code;
    logic [OHM_W-1:0]  ohm;
  } beat_t;

  typedef struct {
    logic [TEMP_W-1:0] temp;
    logic [STAT_W-1:0] stat;
    logic [CH_W-1:0]   ch;
  } temp_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = CMD_CONV;
  logic [CH_W-1:0] channel = '0;
  logic [CODE_W-1:0] adc_code = '0;
  logic [OHM_W-1:0] series_ohm = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [TEMP_W-1:0] temp_centi_c;
  logic [STAT_W-1:0] status;
  logic [CH_W-1:0] channel_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  ntc_beta_temperature_converter dut (.*);

  always #10 clk = ~clk;

  beat_t pending_beats[$];
  temp_res_t temps_due[$];
  beat_t cur_beat;
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_cycle = 0;
  int idle_cycles = 0;

  logic [OHM_W-1:0] series_mem[CHANNELS];
  logic [BETA_W-1:0] beta_cfg;
  logic [OHM_W-1:0] nominal_cfg;
  logic [MV_W-1:0] supply_cfg;
  logic [MV_W-1:0] adcref_cfg;

  const int unsigned ln_points[33] = '{
    0, 2017, 3973, 5873, 7719, 9515, 11262, 12965,
    14624, 16242, 17821, 19364, 20870, 22343, 23783, 25193,
    26573, 27924, 29248, 30546, 31818, 33067, 34292, 35494,
    36675, 37835, 38975, 40095, 41196, 42280, 43345, 44394,
    45426};

  function automatic temp_res_t convert_beat(input beat_t b);
    temp_res_t r;
    logic [63:0] pv, qv, num_r, den_r, qi, rem;
    logic [31:0] ratio, m, idx, fr, frac;
    longint lnq, den, t, num;
    int p;
    r.temp = '0;
    r.ch = b.ch;
    r.stat = ST_OK;
    if (b.cmd == CMD_LOAD) begin
      series_mem[b.ch] = b.ohm;
      r.stat = ST_LOAD;
      return r;
    end
    pv = 64'(supply_cfg) * 64'd65535;
    qv = 64'(b.code) * 64'(adcref_cfg);
    if (qv == 0) begin
      r.stat = ST_ZERO;
    end else if (pv <= qv) begin
      r.stat = ST_NPOS;
    end else begin
      num_r = (pv - qv) * 64'(nominal_cfg);
      den_r = qv * 64'(series_mem[b.ch]);
      if (den_r == 0 || num_r / den_r >= 64'd65536) begin
        ratio = '1;
      end else begin
        qi = num_r / den_r;
        rem = num_r % den_r;
        ratio = 32'((qi << 16) | ((rem << 16) / den_r));
      end
      if (ratio == 0) begin
        r.stat = ST_NPOS;
      end else begin
        p = 31;
        while (p > 0 && !ratio[p]) p--;
        m = ratio << (31 - p);
        idx = (m >> 26) & 32'd31;
        fr = (m >> 10) & 32'hFFFF;
        frac = ln_points[idx] + (((ln_points[idx + 1] - ln_points[idx]) * fr + 32'd32768) >> 16);
        lnq = longint'(p - 16) * 45426 + longint'(frac);
        den = longint'(6553600) * longint'(beta_cfg) - longint'(29815) * lnq;
        if (den <= 0) begin
          r.temp = 16'sh7FFF;
        end else begin
          num = longint'(2981500) * longint'(beta_cfg) * 65536;
          t = (num + den / 2) / den - 27315;
          if (t > 32767) t = 32767;
          if (t < -32768) t = -32768;
          r.temp = t[15:0];
        end
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    logic offer;
    offer = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) temps_due.push_back(convert_beat(cur_beat));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_beats.size() > 0) begin
          cur_beat = pending_beats.pop_front();
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
        in_valid <= offer;
        if (offer) begin
          command <= cur_beat.cmd;
          channel <= cur_beat.ch;
          adc_code <= cur_beat.code;
          series_ohm <= cur_beat.ohm;
        end
      end
    end
  end

  always @(posedge clk) begin
    rx_cycle++;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle >> 9) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    temp_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (temps_due.size() == 0) begin
        report("unexpected beat", status, -1);
      end else begin
        e = temps_due.pop_front();
        if (temp_centi_c !== e.temp)
          report("temp_centi_c", $signed(temp_centi_c), $signed(e.temp));
        if (status !== e.stat) report("status", status, e.stat);
        if (channel_out !== e.ch) report("channel_out", channel_out, e.ch);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BETA: beta_cfg = val[BETA_W-1:0];
      REG_NOMINAL: nominal_cfg = val[OHM_W-1:0];
      REG_SUPPLY: supply_cfg = val[MV_W-1:0];
      default: adcref_cfg = val[MV_W-1:0];
    endcase
  endtask

  task automatic set_regs(input int b, input int n, input int s, input int a);
    write_reg(REG_BETA, b);
    write_reg(REG_NOMINAL, n);
    write_reg(REG_SUPPLY, s);
    write_reg(REG_ADCREF, a);
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || temps_due.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic beat_t mk(input logic cmd, input int ch, input int code, input int ohm);
    beat_t b;
    b.cmd = cmd;
    b.ch = CH_W'(ch);
    b.code = CODE_W'(code);
    b.ohm = OHM_W'(ohm);
    return b;
  endfunction

  function automatic beat_t rand_beat();
    int code, ohm;
    case ($urandom_range(0, 9))
      0: code = $urandom_range(0, 15);
      1: code = $urandom_range(65520, 65535);
      2, 3: code = $urandom_range(0, 65535);
      default: code = $urandom_range(6000, 45000);
    endcase
    case ($urandom_range(0, 9))
      0: ohm = $urandom_range(0, 131071);
      1: ohm = ($urandom_range(0, 1) == 1) ? 0 : 131071;
      default: ohm = $urandom_range(500, 60000);
    endcase
    return mk(($urandom_range(0, 4) == 0) ? CMD_LOAD : CMD_CONV,
              $urandom_range(0, 7), code, ohm);
  endfunction

  task automatic run_random(input int count);
    repeat (count) pending_beats.push_back(rand_beat());
    drain();
  endtask

  initial begin
    for (int k = 0; k < CHANNELS; k++) series_mem[k] = series_init(k);
    beta_cfg = BETA_RESET;
    nominal_cfg = NOMINAL_RESET;
    supply_cfg = SUPPLY_RESET;
    adcref_cfg = ADCREF_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    pending_beats.push_back(mk(CMD_CONV, 0, 30000, 0));
    pending_beats.push_back(mk(CMD_CONV, 5, 0, 0));
    pending_beats.push_back(mk(CMD_CONV, 1, 65535, 131071));
    pending_beats.push_back(mk(CMD_CONV, 2, 1, 0));
    pending_beats.push_back(mk(CMD_CONV, 3, 43000, 0));
    pending_beats.push_back(mk(CMD_LOAD, 7, 65535, 0));
    pending_beats.push_back(mk(CMD_CONV, 7, 20000, 0));
    pending_beats.push_back(mk(CMD_LOAD, 6, 0, 131071));
    pending_beats.push_back(mk(CMD_CONV, 6, 200, 0));
    pending_beats.push_back(mk(CMD_CONV, 6, 65535, 0));
    pending_beats.push_back(mk(CMD_LOAD, 4, 0, 1));
    pending_beats.push_back(mk(CMD_CONV, 4, 1, 0));
    pending_beats.push_back(mk(CMD_CONV, 4, 40000, 0));
    pending_beats.push_back(mk(CMD_LOAD, 0, 0, 10000));
    pending_beats.push_back(mk(CMD_CONV, 0, 43690, 0));
    drain();

    set_regs(3977, 10000, 1000, 5000);
    pending_beats.push_back(mk(CMD_CONV, 1, 13107, 0));
    pending_beats.push_back(mk(CMD_CONV, 1, 13106, 0));
    pending_beats.push_back(mk(CMD_CONV, 2, 65535, 0));
    run_random(100);

    set_regs(1, 1, 1, 1);
    run_random(110);

    set_regs(65535, 131071, 5000, 5000);
    pending_beats.push_back(mk(CMD_CONV, 3, 65535, 0));
    run_random(110);

    set_regs(3977, 10000, 3300, 2500);
    hold_req++;
    run_random(150);

    set_regs($urandom_range(1, 65535), $urandom_range(1, 131071),
             $urandom_range(1, 5000), $urandom_range(1, 5000));
    run_random(100);

    set_regs($urandom_range(2000, 5000), $urandom_range(1000, 100000),
             $urandom_range(2000, 5000), $urandom_range(1000, 5000));
    run_random(150);

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
